[hdl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A concurrent property, sampled on the rising clock and switched off in reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication that must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    `ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

[hdl/tmps_pkg.sv]
package tmps_pkg;

    localparam int VALUE_W = 16;
    localparam int SUM_W   = 22;
    localparam int CFG_W   = 7;
    localparam int OUT_TDATA_W = 24;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic first_row;
        logic col0;
        logic right_edge;
        logic last;
    } tmps_flags_t;

    localparam int FLAGS_W = $bits(tmps_flags_t);

    // Clamp a sum that is one bit wider than a stored sum.
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
        logic signed [SUM_W-1:0] r;
        if (x[SUM_W] != x[SUM_W-1])
        begin
            r = x[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            r = x[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/tmps_ram.sv]
module tmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/tmps_queue.sv]
module tmps_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/tmps_front.sv]
module tmps_front #(
    parameter int MAX_ROWS = 64,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tmps_pkg::VALUE_W-1:0]  s_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmps_pkg::CFG_W-1:0]    cfg_data,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [tmps_pkg::VALUE_W-1:0]  q_value,
    output logic [RW-1:0]                 q_col,
    output tmps_pkg::tmps_flags_t         q_flags
);

    localparam int EW = (RW + 1 > tmps_pkg::CFG_W) ? RW + 1 : tmps_pkg::CFG_W;

    logic [tmps_pkg::CFG_W-1:0] num_rows_reg;
    logic [RW-1:0]              row_reg, row_next;
    logic [RW-1:0]              col_reg, col_next;
    logic [EW-1:0]              rows_cfg, rows_eff, row_plus1;
    logic                       accept;
    tmps_pkg::tmps_flags_t      flags;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_ready;
    assign q_valid   = s_tvalid;
    assign q_value   = s_tdata;
    assign q_col     = col_reg;
    assign q_flags   = flags;
    assign accept    = s_tvalid && q_ready;

    always_comb
    begin
        rows_cfg  = EW'(num_rows_reg);
        row_plus1 = EW'(row_reg) + EW'(1);
        if (rows_cfg == '0)
        begin
            rows_eff = EW'(1);
        end
        else if (rows_cfg > EW'(MAX_ROWS))
        begin
            rows_eff = EW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_cfg;
        end

        flags.first_row  = (row_reg == '0);
        flags.col0       = (col_reg == '0);
        flags.right_edge = (col_reg == row_reg);
        flags.last       = flags.right_edge && (row_plus1 >= rows_eff);

        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (flags.right_edge)
            begin
                col_next = '0;
                row_next = flags.last ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= tmps_pkg::CFG_W'(1);
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                num_rows_reg <= cfg_data;
            end
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

[hdl/tmps_back.sv]
module tmps_back #(
    parameter int MAX_ROWS = 64,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tmps_pkg::VALUE_W-1:0]     in_value,
    input  logic [RW-1:0]                    in_col,
    input  tmps_pkg::tmps_flags_t            in_flags,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tmps_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int SW = tmps_pkg::SUM_W;

    logic                                rd_valid_reg;
    logic signed [tmps_pkg::VALUE_W-1:0] rd_value_reg;
    logic [RW-1:0]                       rd_col_reg;
    tmps_pkg::tmps_flags_t               rd_flags_reg;
    logic                                byp_hit_reg;
    logic signed [SW-1:0]                byp_data_reg;
    logic signed [SW-1:0]                left_carry_reg;
    logic signed [SW-1:0]                best_reg;
    logic                                out_valid_reg;
    logic signed [SW-1:0]                out_data_reg;

    logic [SW-1:0]        ram_rd_data;
    logic signed [SW-1:0] up, pick, sum, best_next;
    logic signed [SW:0]   sum_wide;
    logic                 commit, pop;

    tmps_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ROWS)
    ) u_row_sums (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (rd_col_reg),
        .wr_data (sum),
        .rd_en   (pop),
        .rd_addr (in_col),
        .rd_data (ram_rd_data)
    );

    // The end of a triangle needs the output slot; other entries never wait.
    assign commit   = rd_valid_reg && (!rd_flags_reg.last || !out_valid_reg || m_tready);
    assign pop      = in_valid && (!rd_valid_reg || commit);
    assign in_ready = (!rd_valid_reg || commit);

    always_comb
    begin
        up = byp_hit_reg ? byp_data_reg : $signed(ram_rd_data);
        priority if (rd_flags_reg.col0)
        begin
            pick = up;
        end
        else if (rd_flags_reg.right_edge)
        begin
            pick = left_carry_reg;
        end
        else
        begin
            pick = (left_carry_reg > up) ? left_carry_reg : up;
        end
        sum_wide = (SW + 1)'(rd_value_reg) + (SW + 1)'(pick);
        sum = rd_flags_reg.first_row ? SW'(rd_value_reg) : tmps_pkg::sat_sum(sum_wide);
        best_next = (rd_flags_reg.col0 || sum > best_reg) ? sum : best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                rd_valid_reg <= 1'b0;
            end

            if (commit && rd_flags_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_value_reg <= $signed(in_value);
            rd_col_reg   <= in_col;
            rd_flags_reg <= in_flags;
            // A read that meets the write of the same sum sees the old word,
            // so the new sum is kept aside for it.
            byp_hit_reg  <= commit && (rd_col_reg == in_col);
            byp_data_reg <= sum;
        end
        if (commit)
        begin
            best_reg <= best_next;
            if (!rd_flags_reg.first_row)
            begin
                left_carry_reg <= up;
            end
            if (rd_flags_reg.last)
            begin
                out_data_reg <= best_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tmps_pkg::OUT_TDATA_W - SW){1'b0}}, out_data_reg};

endmodule

[hdl/triangle_max_path_sum_top.sv]
// Maximum top-to-bottom path sum of a number triangle. Entries arrive in row
// order on the slave stream, one per cycle at full rate; each takes one
// read-modify-write of a MAX_ROWS-deep row-sum memory (one read and one write
// port per cycle), so a steady stream needs no gaps. After the last entry of
// the row set by num_rows (0 counts as 1, values above MAX_ROWS as MAX_ROWS)
// the row maximum passes the queue, read registers and output register to the
// master stream, and the next request starts a new triangle at row 0. Input
// stalls only while a finished result is held by the master and the two-entry
// queue is full. Write num_rows only while no triangle is in progress.
module triangle_max_path_sum_top #(
    parameter int MAX_ROWS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [21:0] best_sum, [23:22] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data    // num_rows
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int QW = tmps_pkg::VALUE_W + RW + tmps_pkg::FLAGS_W;

    logic                           fq_valid, fq_ready;
    logic [tmps_pkg::VALUE_W-1:0]   fq_value;
    logic [RW-1:0]                  fq_col;
    tmps_pkg::tmps_flags_t          fq_flags;
    logic                           qb_valid, qb_ready;
    logic [QW-1:0]                  qb_data;
    logic [tmps_pkg::VALUE_W-1:0]   qb_value;
    logic [RW-1:0]                  qb_col;
    tmps_pkg::tmps_flags_t          qb_flags;

    tmps_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_value   (fq_value),
        .q_col     (fq_col),
        .q_flags   (fq_flags)
    );

    tmps_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  ({fq_value, fq_col, fq_flags}),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    assign {qb_value, qb_col, qb_flags} = qb_data;

    tmps_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (qb_valid),
        .in_ready (qb_ready),
        .in_value (qb_value),
        .in_col   (qb_col),
        .in_flags (qb_flags),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hdl/tmps_checker.sv]
`include "assert_macros.svh"

module tmps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A result that is not taken stays offered.
    `ASSERT_PROP(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")

    // Padding above the sum is always zero.
    `ASSERT_IMPLIES(a_out_pad, clk, rst_n, m_tvalid, m_tdata[23:22] == 2'b00, "result padding not zero")

    // If no result was held back in the last cycle, the queue has a free slot.
    `ASSERT_PROP(a_in_free, clk, rst_n, $past(!m_tvalid || m_tready) |-> s_tready, "input stalled with no held result")

    // A held result keeps its value.
    `ASSERT_PROP(a_out_stable, clk, rst_n, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result changed while stalled")

endmodule

bind triangle_max_path_sum_top tmps_checker u_tmps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[verif/triangle_max_path_sum_top_test.sv]
module triangle_max_path_sum_top_test;

    localparam int ROWS_MAX = 64;

    typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN} fill_kind_t;

    // Tracks the expected row maxima and checks each one that leaves the block.
    class path_sum_scoreboard_t;
        logic signed [tmps_pkg::SUM_W-1:0] row_sums [ROWS_MAX];
        logic signed [tmps_pkg::SUM_W-1:0] left_carry;
        logic signed [tmps_pkg::SUM_W-1:0] best_so_far;
        logic [tmps_pkg::CFG_W-1:0]        num_rows;
        int unsigned                       row_at;
        int unsigned                       col_at;
        logic signed [tmps_pkg::SUM_W-1:0] pending_best_sums [$];
        int                                mismatch_count;

        function new();
            foreach (row_sums[k])
            begin
                row_sums[k] = '0;
            end
            left_carry = '0;
            best_so_far = '0;
            num_rows = 7'd1;
            row_at = 0;
            col_at = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned rows_in_use();
            if (num_rows == 0)
            begin
                return 1;
            end
            if (num_rows > ROWS_MAX)
            begin
                return ROWS_MAX;
            end
            return num_rows;
        endfunction

        function void set_rows(logic [tmps_pkg::CFG_W-1:0] n);
            num_rows = n;
        endfunction

        function int pending();
            return pending_best_sums.size();
        endfunction

        // Works out the best path sum ending at this entry and advances the position.
        function void note_entry(logic signed [tmps_pkg::VALUE_W-1:0] v);
            int unsigned i;
            int unsigned j;
            int          up;
            int          pick;
            int          s;
            i = row_at;
            j = col_at;
            if (i == 0)
            begin
                s = v;
            end
            else
            begin
                up = (j < i) ? int'(row_sums[j]) : 0;
                if (j == 0)
                begin
                    pick = up;
                end
                else if (j == i)
                begin
                    pick = left_carry;
                end
                else
                begin
                    pick = (int'(left_carry) > up) ? int'(left_carry) : up;
                end
                s = int'(v) + pick;
                if (s > int'(tmps_pkg::SUM_MAX))
                begin
                    s = int'(tmps_pkg::SUM_MAX);
                end
                else if (s < int'(tmps_pkg::SUM_MIN))
                begin
                    s = int'(tmps_pkg::SUM_MIN);
                end
                // Save the value above before the write below overwrites it.
                left_carry = tmps_pkg::SUM_W'(up);
            end
            row_sums[j] = tmps_pkg::SUM_W'(s);
            if (j == 0 || s > int'(best_so_far))
            begin
                best_so_far = tmps_pkg::SUM_W'(s);
            end
            if (j == i)
            begin
                if (i + 1 >= rows_in_use())
                begin
                    pending_best_sums.push_back(best_so_far);
                    row_at = 0;
                    col_at = 0;
                    left_carry = '0;
                end
                else
                begin
                    row_at = i + 1;
                    col_at = 0;
                end
            end
            else
            begin
                col_at = j + 1;
            end
        endfunction

        function void check_best_sum(logic [tmps_pkg::OUT_TDATA_W-1:0] tdata);
            logic signed [tmps_pkg::SUM_W-1:0] want;
            if (pending_best_sums.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected result: tdata %h with nothing outstanding", tdata);
                end
                return;
            end
            want = pending_best_sums.pop_front();
            if (tdata !== {{(tmps_pkg::OUT_TDATA_W-tmps_pkg::SUM_W){1'b0}}, want})
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("best_sum mismatch: expected %0d, got %0d (tdata %h)",
                             want, $signed(tdata[tmps_pkg::SUM_W-1:0]), tdata);
                end
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [tmps_pkg::VALUE_W-1:0]     s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [tmps_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [tmps_pkg::CFG_W-1:0]       cfg_data;

    path_sum_scoreboard_t sb;
    bit                   calm_tail;
    int                   hold_request;
    int                   sent_count;

    triangle_max_path_sum_top #(
        .MAX_ROWS (ROWS_MAX)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_entry(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_best_sum(m_tdata);
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.set_rows(cfg_data);
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
                m_tready <= 1'b1;
            end
            else if (!calm_tail && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [tmps_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one entry and returns at the falling edge after it is taken.
    task automatic send_value(input logic [tmps_pkg::VALUE_W-1:0] v);
        int gap;
        if (!calm_tail && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_triangle(input int unsigned rows, input fill_kind_t fill);
        int unsigned n;
        for (n = 0; n < rows * (rows + 1) / 2; n++)
        begin
            case (fill)
                FILL_MAX: send_value(16'h7FFF);
                FILL_MIN: send_value(16'h8000);
                default:  send_value(pick_value());
            endcase
        end
    endtask

    // Waits until the block has nothing left to deliver, then writes the row count.
    task automatic write_rows(input logic [tmps_pkg::CFG_W-1:0] n);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                         triangles;
        int unsigned                rows;
        logic [tmps_pkg::CFG_W-1:0] pick;
        sb = new();
        calm_tail = 1'b0;
        hold_request = 0;
        sent_count = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // One-row triangles at the reset row count: the result is the entry itself.
        send_value(16'h7FFF);
        send_value(16'h8000);
        send_value(16'h0000);
        send_value(16'hFFFF);

        // A row count of zero behaves as one.
        write_rows(7'd0);
        send_value(16'h0001);
        send_value(16'h8000);

        // Three rows: equal sums above a middle entry, and a right edge that wins.
        write_rows(7'd3);
        send_value(16'd10);
        send_value(-16'sd20);
        send_value(-16'sd20);
        send_value(16'd1);
        send_value(16'd0);
        send_value(16'h7FFF);

        // Every sum negative, so the maximum is negative too.
        write_rows(7'd2);
        send_triangle(2, FILL_MIN);

        // Deeper triangles at the top and bottom of the entry range.
        write_rows(7'd16);
        send_triangle(16, FILL_MAX);
        send_triangle(16, FILL_MIN);

        // Hold the result side off so that the block fills up and stalls its input.
        write_rows(7'd1);
        hold_request = 300;
        send_triangle(1, FILL_RANDOM);
        repeat (15) send_value(pick_value());

        while (sent_count < 500)
        begin
            case ($urandom_range(0, 9))
                0:       pick = 7'd0;
                1:       pick = 7'($urandom_range(7, 14));
                default: pick = 7'($urandom_range(1, 6));
            endcase
            write_rows(pick);
            rows = (pick == 0) ? 1 : pick;
            triangles = $urandom_range(1, 4);
            repeat (triangles)
            begin
                send_triangle(rows, FILL_RANDOM);
            end
            if (sent_count >= 400)
            begin
                calm_tail = 1'b1;
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[triangle_max_path_sum_top.f]
+incdir+hdl
hdl/tmps_pkg.sv
hdl/tmps_ram.sv
hdl/tmps_queue.sv
hdl/tmps_front.sv
hdl/tmps_back.sv
hdl/triangle_max_path_sum_top.sv
hdl/tmps_checker.sv
verif/triangle_max_path_sum_top_test.sv
